// ===== design/ldfl_pkg.sv =====
// Shared types and constants for the launch detect flight logger.
package ldfl_pkg;

   localparam int ALT_W    = 16;
   localparam int SUPPLY_W = 10;
   localparam int INDEX_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Item function codes.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_ALARM_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_VALUE         = 2'd2;

   // Values after reset.
   localparam logic [ALT_W-1:0]    THRESHOLD_RESET = 16'd50;
   localparam logic [SUPPLY_W-1:0] ALARM_RESET     = 10'd563;
   localparam logic [ALT_W-1:0]    FILL_RESET      = 16'd1000;

   typedef struct packed {
      logic                func;
      logic [ALT_W-1:0]    altitude;
      logic [SUPPLY_W-1:0] supply_level;
      logic [INDEX_W-1:0]  log_index;
   } req_type;

   typedef struct packed {
      logic [ALT_W-1:0] filtered_altitude;
      logic             launched;
      logic             low_battery;
      logic             log_full;
      logic [ALT_W-1:0] read_data;
   } rsp_type;

endpackage

// ===== design/ldfl_log_ram.sv =====
// Log memory: one write port and one read port with registered read data.
module ldfl_log_ram
   import ldfl_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [ALT_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [ALT_W-1:0] rd_data
);

   logic [ALT_W-1:0] mem_ff [DEPTH];
   logic [ALT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/launch_detect_flight_logger.sv =====
// Top level of the launch detect flight logger.
//
// Items arrive on the req_ channel (valid/ready). A sample item (func 0)
// carries an altitude and a supply reading; a read item (func 1) names one
// log entry. Every item yields exactly one result on the rsp_ channel,
// holding the filtered altitude, the sticky launched and low-battery flags,
// the log-full flag and, for reads, the log entry. The user writes the
// configuration registers through csr_ only while idle; no check enforces it.
//
// Timing: one item is in work at a time. A plain sample goes from the idle
// state to the response state, which loads the output register and returns
// to idle for the next item. The launch sample also passes the second write
// state (slot 0 and the first logged slot go through the single write port
// one after the other), and a read passes the read state for the RAM data.
// The result sits in an output register, so the next item is accepted while
// a result still waits; if the receiver stalls further, the finished item
// waits in the response state and req_ready stays low.
// Reset clears the filter and flags at once. No clearing pass is needed: the
// log is never written before launch, and after launch entries at or above
// the write slot read as the fill value latched at launch.
module launch_detect_flight_logger
   import ldfl_pkg::*;
#(
   parameter int LOG_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Address width, write slot width (holds LOG_DEPTH itself) and a compare
   // width wide enough for both the slot and the read index.
   localparam int AW = $clog2(LOG_DEPTH);
   localparam int SW = $clog2(LOG_DEPTH + 1);
   localparam int CW = (SW > INDEX_W) ? SW : INDEX_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_WRITE2 = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   // Where a read item takes its data from.
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_RESET,
      RD_MEM,
      RD_FILL
   } rd_sel_type;

   state_type         state_ff, state_in;
   logic [ALT_W-1:0]  prev_ff, prev_in;
   logic              seeded_ff, seeded_in;
   logic              launch_ff, launch_in;
   logic              batt_ff, batt_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [ALT_W-1:0]  thr_ff, thr_in;
   logic [SUPPLY_W-1:0] alarm_ff, alarm_in;
   logic [ALT_W-1:0]  fill_cfg_ff, fill_cfg_in;
   logic [ALT_W-1:0]  fill_latch_ff, fill_latch_in;
   rd_sel_type        rd_sel_ff, rd_sel_in;
   logic [ALT_W-1:0]  rdata_ff, rdata_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [ALT_W-1:0]  ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [ALT_W-1:0]  ram_rdata;

   logic              accept;
   logic [ALT_W:0]    sum;
   logic [ALT_W-1:0]  new_filtered;
   logic [ALT_W:0]    launch_limit;
   logic              launch_hit;
   logic [CW-1:0]     idx_c;
   logic [CW-1:0]     slot_c;
   logic              slot_open;
   logic              log_full;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Half-weight filter and launch test, both on 17-bit sums.
   assign sum          = {1'b0, req_data.altitude} + {1'b0, prev_ff};
   assign new_filtered = sum[ALT_W:1];
   assign launch_limit = {1'b0, prev_ff} + {1'b0, thr_ff};
   assign launch_hit   = ({1'b0, new_filtered} > launch_limit);

   assign idx_c     = CW'(req_data.log_index);
   assign slot_c    = CW'(slot_ff);
   assign log_full  = (slot_ff == SW'(LOG_DEPTH));
   assign slot_open = !log_full;

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      seeded_in     = seeded_ff;
      launch_in     = launch_ff;
      batt_in       = batt_ff;
      slot_in       = slot_ff;
      fill_latch_in = fill_latch_ff;
      rd_sel_in     = rd_sel_ff;
      rdata_in      = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff[AW-1:0];
      ram_wdata     = new_filtered;
      ram_re        = 1'b0;
      ram_raddr     = idx_c[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_READ) begin
                  // Decide the source now; state does not move during a read.
                  if (idx_c >= CW'(LOG_DEPTH)) begin
                     rd_sel_in = RD_ZERO;
                  end else if (!launch_ff) begin
                     rd_sel_in = RD_RESET;
                  end else if (idx_c < slot_c) begin
                     rd_sel_in = RD_MEM;
                  end else begin
                     rd_sel_in = RD_FILL;
                  end
                  ram_re   = 1'b1;
                  state_in = S_READ;
               end else begin
                  rdata_in = '0;
                  state_in = S_RESP;
                  if (!seeded_ff) begin
                     prev_in   = req_data.altitude;
                     seeded_in = 1'b1;
                  end else begin
                     prev_in = new_filtered;
                     if (!launch_ff) begin
                        if (launch_hit) begin
                           // Slot 0 takes the pre-launch value now; the new
                           // value goes to the write slot in the next cycle.
                           launch_in     = 1'b1;
                           fill_latch_in = fill_cfg_ff;
                           ram_we        = 1'b1;
                           ram_waddr     = '0;
                           ram_wdata     = prev_ff;
                           state_in      = S_WRITE2;
                        end else if (req_data.supply_level >= alarm_ff) begin
                           batt_in = 1'b1;
                        end
                     end else if (slot_open) begin
                        ram_we  = 1'b1;
                        slot_in = slot_ff + SW'(1);
                     end
                  end
               end
            end
         end
         S_READ: begin
            case (rd_sel_ff)
               RD_ZERO:  rdata_in = '0;
               RD_RESET: rdata_in = FILL_RESET;
               RD_MEM:   rdata_in = ram_rdata;
               RD_FILL:  rdata_in = fill_latch_ff;
               default:  rdata_in = '0;
            endcase
            state_in = S_RESP;
         end
         S_WRITE2: begin
            // The filter already holds the launch sample's value.
            ram_we    = 1'b1;
            ram_wdata = prev_ff;
            slot_in   = slot_ff + SW'(1);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.filtered_altitude = prev_ff;
               rsp_data_in.launched          = launch_ff;
               rsp_data_in.low_battery       = batt_ff;
               rsp_data_in.log_full          = log_full;
               rsp_data_in.read_data         = rdata_ff;
               state_in                      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Configuration writes; an index beyond the list is ignored.
   always_comb begin
      thr_in      = thr_ff;
      alarm_in    = alarm_ff;
      fill_cfg_in = fill_cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LAUNCH_THRESHOLD:   thr_in      = csr_wdata;
            CSR_SUPPLY_ALARM_LEVEL: alarm_in    = csr_wdata[SUPPLY_W-1:0];
            CSR_FILL_VALUE:         fill_cfg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         seeded_ff    <= 1'b0;
         launch_ff    <= 1'b0;
         batt_ff      <= 1'b0;
         slot_ff      <= SW'(1);
         thr_ff       <= THRESHOLD_RESET;
         alarm_ff     <= ALARM_RESET;
         fill_cfg_ff  <= FILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         seeded_ff    <= seeded_in;
         launch_ff    <= launch_in;
         batt_ff      <= batt_in;
         slot_ff      <= slot_in;
         thr_ff       <= thr_in;
         alarm_ff     <= alarm_in;
         fill_cfg_ff  <= fill_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      fill_latch_ff <= fill_latch_in;
      rd_sel_ff     <= rd_sel_in;
      rdata_ff      <= rdata_in;
      rsp_data_ff   <= rsp_data_in;
   end

   ldfl_log_ram #(
      .DEPTH (LOG_DEPTH),
      .AW    (AW)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/ldfl_checker.sv =====
// Port-level assertions for the flight logger, bound to the top level.
module ldfl_checker
   import ldfl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic [1:0] pending_ff;
   logic       seen_launch_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         seen_launch_ff <= 1'b0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
         if (rsp_fire && rsp_data.launched) begin
            seen_launch_ff <= 1'b1;
         end
      end
   end

   // A result that waits keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result without an item behind it, and at most two items in the block.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff == 2'd1 || pending_ff == 2'd2))
      else $error("result without an item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("item accepted with two items in flight");

   // Launch is sticky.
   a_launch_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_launch_ff |-> rsp_data.launched)
      else $error("launched flag dropped");

   // The log only fills after launch.
   a_full_after_launch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.log_full |-> rsp_data.launched)
      else $error("log full before launch");

endmodule

bind launch_detect_flight_logger ldfl_checker u_ldfl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the launch detect flight logger.
`timescale 1ns / 100ps

module tb_top;
   import ldfl_pkg::*;

   localparam int LOG_DEPTH = 256;

   // Receiver back-pressure: one long stall partway through the post-launch
   // traffic, long enough for the block to fill up and drop req_ready.
   localparam int LONG_HOLD_AT = 1100;
   localparam int LONG_HOLD    = 150;

   // Cycles in which neither channel moves before the run is declared hung.
   // The limit lies well above the long receiver stall.
   localparam int QUIET_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LAUNCH_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   launch_detect_flight_logger #(.LOG_DEPTH(LOG_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state. It mirrors the block: the filter, the sticky flags,
   // the next log slot, the log itself and the three registers.
   // ------------------------------------------------------------------
   logic [ALT_W-1:0]    alt_filter = '0;
   bit                  is_seeded = 1'b0;
   bit                  is_launched = 1'b0;
   bit                  battery_low = 1'b0;
   int                  log_slot = 1;
   logic [ALT_W-1:0]    flight_log [LOG_DEPTH];
   logic [ALT_W-1:0]    threshold_cfg = THRESHOLD_RESET;
   logic [SUPPLY_W-1:0] alarm_cfg = ALARM_RESET;
   logic [ALT_W-1:0]    fill_cfg = FILL_RESET;

   // Reports predicted for accepted items, oldest first.
   rsp_type pending_reports [$];
   int      error_count = 0;

   // The low-battery latch and the rule that no battery check happens at or
   // after launch cannot both be seen in one run, since both flags are
   // sticky and reset comes only once. The seed picks which one this run
   // exercises: with early_battery set, supply readings before launch may
   // reach the alarm level; otherwise they always stay below it.
   bit early_battery;

   bit sender_burst = 1'b0;

   // Works out the report for one accepted item and advances the state.
   function automatic rsp_type predict_flight(input req_type item);
      rsp_type          report;
      logic [ALT_W:0]   sum;
      logic [ALT_W:0]   ceiling;
      logic [ALT_W-1:0] smoothed;
      report = '0;
      if (item.func == FUNC_READ) begin
         if (int'(item.log_index) < LOG_DEPTH) begin
            report.read_data = flight_log[item.log_index];
         end
      end else if (!is_seeded) begin
         // The first sample only seeds the filter.
         alt_filter = item.altitude;
         is_seeded = 1'b1;
      end else begin
         sum = {1'b0, item.altitude} + {1'b0, alt_filter};
         smoothed = sum[ALT_W:1];
         // The rise is compared in 17 bits, so a large threshold never wraps.
         ceiling = {1'b0, alt_filter} + {1'b0, threshold_cfg};
         if (!is_launched && {1'b0, smoothed} > ceiling) begin
            is_launched = 1'b1;
            foreach (flight_log[i]) flight_log[i] = fill_cfg;
            flight_log[0] = alt_filter;
         end
         alt_filter = smoothed;
         if (is_launched) begin
            if (log_slot < LOG_DEPTH) begin
               flight_log[log_slot] = smoothed;
               log_slot++;
            end
         end else if (item.supply_level >= alarm_cfg) begin
            battery_low = 1'b1;
         end
      end
      report.filtered_altitude = alt_filter;
      report.launched = is_launched;
      report.low_battery = battery_low;
      report.log_full = (log_slot >= LOG_DEPTH);
      return report;
   endfunction

   // Supply readings: below the alarm level while the run keeps the battery
   // flag clear before launch, otherwise biased toward the edges.
   function automatic logic [SUPPLY_W-1:0] pick_supply();
      if (!is_launched && !early_battery && alarm_cfg != 0) begin
         return SUPPLY_W'($urandom_range(0, int'(alarm_cfg) - 1));
      end
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return alarm_cfg;
         3: return alarm_cfg - 1'b1;
         default: return SUPPLY_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Altitude that moves the filter by a rise of at most max_rise, with the
   // exact limit hit often. Clamping at the range ends keeps that bound.
   function automatic logic [ALT_W-1:0] pad_altitude(input int max_rise);
      int rise;
      int target;
      int alt;
      if ($urandom_range(0, 7) == 0) begin
         rise = max_rise;
      end else begin
         rise = int'($urandom_range(0, max_rise + 400)) - 400;
      end
      target = int'(alt_filter) + rise;
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      alt = 2 * target - int'(alt_filter) + int'($urandom_range(0, 1));
      if (alt < 0) alt = 0;
      if (alt > 65535) alt = 65535;
      return alt[ALT_W-1:0];
   endfunction

   // Next random item. Before launch a max_rise below 65535 keeps samples
   // on the pad (no launch); 65535 means free altitudes. After launch reads
   // favor slot 0 and the slots around the write position.
   function automatic req_type next_item(input int max_rise);
      req_type item;
      int      pick;
      int      slot;
      item.func = FUNC_SAMPLE;
      item.altitude = ALT_W'($urandom);
      item.supply_level = pick_supply();
      item.log_index = INDEX_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         item.func = FUNC_READ;
         if (is_launched && pick == 0) begin
            item.log_index = '0;
         end else if (is_launched && pick == 1) begin
            slot = log_slot + int'($urandom_range(0, 2)) - 1;
            if (slot > LOG_DEPTH - 1) slot = LOG_DEPTH - 1;
            item.log_index = INDEX_W'(slot);
         end
      end else if (!is_launched && max_rise < 65535) begin
         item.altitude = pad_altitude(max_rise);
      end else if (pick == 3) begin
         item.altitude = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      return item;
   endfunction

   // Offers one item after a random gap, waits for it to be taken and queues
   // the predicted report. Valid is lowered only when a gap follows, so a
   // back-to-back item never sees valid dropped and raised in one step.
   task automatic offer_item(input req_type item);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(predict_flight(item));
   endtask

   // Stops offering and waits until every predicted report has come back.
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_LAUNCH_THRESHOLD:   threshold_cfg = value;
         CSR_SUPPLY_ALARM_LEVEL: alarm_cfg = value[SUPPLY_W-1:0];
         CSR_FILL_VALUE:         fill_cfg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Directed items, run with the reset register values (threshold 50,
   // alarm 563). Rows marked fixed carry a report typed in by hand; the
   // rest are checked against the predictor. All supplies stay below the alarm
   // level but on the seeding sample and one read, which make no battery check.
   // ------------------------------------------------------------------
   typedef struct packed {
      logic                func;
      logic [ALT_W-1:0]    altitude;
      logic [SUPPLY_W-1:0] supply_level;
      logic [INDEX_W-1:0]  log_index;
      logic                fixed;
      logic [ALT_W-1:0]    want_filtered;
      logic [ALT_W-1:0]    want_read;
   } probe_row_type;

   localparam int PROBE_ROWS = 14;

   probe_row_type probe_table [PROBE_ROWS] = '{
      // Reads before the filter is seeded return the reset fill value.
      '{FUNC_READ,   16'd0,     10'd0,    8'd0,   1'b1, 16'd0,     16'd1000},
      '{FUNC_READ,   16'd0,     10'd0,    8'd255, 1'b1, 16'd0,     16'd1000},
      // Seeding sample at full scale, with a supply above the alarm level.
      '{FUNC_SAMPLE, 16'd65535, 10'd1023, 8'd0,   1'b1, 16'd65535, 16'd0},
      // Half-weight filter from full scale toward zero.
      '{FUNC_SAMPLE, 16'd0,     10'd0,    8'd255, 1'b1, 16'd32767, 16'd0},
      '{FUNC_SAMPLE, 16'd0,     10'd562,  8'd0,   1'b0, 16'd0,     16'd0},
      // Rise of exactly the threshold does not launch.
      '{FUNC_SAMPLE, 16'd16483, 10'd0,    8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_READ,   16'd0,     10'd0,    8'd1,   1'b0, 16'd0,     16'd0},
      '{FUNC_SAMPLE, 16'd0,     10'd561,  8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_SAMPLE, 16'd1,     10'd1,    8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_SAMPLE, 16'd0,     10'd0,    8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_SAMPLE, 16'd2154,  10'd0,    8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_READ,   16'd65535, 10'd1023, 8'd128, 1'b0, 16'd0,     16'd0},
      '{FUNC_SAMPLE, 16'd2,     10'd300,  8'd0,   1'b0, 16'd0,     16'd0},
      '{FUNC_READ,   16'd0,     10'd0,    8'd0,   1'b0, 16'd0,     16'd0}
   };

   // ------------------------------------------------------------------
   // Result side: random stalls, one long stall, and the field checks.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : report_side
      int      ready_wait;
      int      rsp_count;
      int      hold;
      bit      rsp_burst;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_wait = 0;
         rsp_count = 0;
         rsp_burst = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_reports.size() == 0) begin
            $error("report arrived with no item outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.filtered_altitude !== want.filtered_altitude) begin
               $error("filtered_altitude: expected %0d, actual %0d",
                      want.filtered_altitude, rsp_data.filtered_altitude);
               error_count++;
            end
            if (rsp_data.launched !== want.launched) begin
               $error("launched: expected %0d, actual %0d",
                      want.launched, rsp_data.launched);
               error_count++;
            end
            if (rsp_data.low_battery !== want.low_battery) begin
               $error("low_battery: expected %0d, actual %0d",
                      want.low_battery, rsp_data.low_battery);
               error_count++;
            end
            if (rsp_data.log_full !== want.log_full) begin
               $error("log_full: expected %0d, actual %0d",
                      want.log_full, rsp_data.log_full);
               error_count++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data: expected %0d, actual %0d",
                      want.read_data, rsp_data.read_data);
               error_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         hold = rsp_burst ? 0 : $urandom_range(0, 14);
         // The sender keeps offering during this stretch, so the block's
         // output register and response stage both fill and intake stalls.
         if (rsp_count == LONG_HOLD_AT) hold = LONG_HOLD;
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            ready_wait = hold - 1;
         end
      end else if (!rsp_ready) begin
         if (ready_wait == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            ready_wait--;
         end
      end
   end

   // Hang detection: ends the run when neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      req_type item;
      rsp_type fixed_report;
      foreach (flight_log[i]) flight_log[i] = FILL_RESET;
      early_battery = ($urandom_range(0, 1) == 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         item.func = probe_table[i].func;
         item.altitude = probe_table[i].altitude;
         item.supply_level = probe_table[i].supply_level;
         item.log_index = probe_table[i].log_index;
         offer_item(item);
         // A hand-typed report replaces the prediction just queued; the
         // report itself cannot come back before the next clock edge.
         if (probe_table[i].fixed) begin
            fixed_report = '0;
            fixed_report.filtered_altitude = probe_table[i].want_filtered;
            fixed_report.read_data = probe_table[i].want_read;
            pending_reports[pending_reports.size() - 1] = fixed_report;
         end
      end

      // Largest threshold: no rise can launch, even with free altitudes,
      // which catches a threshold sum that wraps at 16 bits. Changing the
      // fill value now must leave the log as it was at reset.
      drain_reports();
      write_csr(CSR_LAUNCH_THRESHOLD, '1);
      write_csr(CSR_SUPPLY_ALARM_LEVEL, CSR_DATA_W'(1023));
      write_csr(CSR_FILL_VALUE, '0);
      repeat (300) offer_item(next_item(65535));

      // Mid-range threshold with samples kept on the pad, often rising by
      // exactly the threshold. The fill value at launch is full scale.
      drain_reports();
      write_csr(CSR_LAUNCH_THRESHOLD, CSR_DATA_W'($urandom_range(1, 3000)));
      write_csr(CSR_SUPPLY_ALARM_LEVEL, CSR_DATA_W'($urandom_range(1, 1022)));
      write_csr(CSR_FILL_VALUE, '1);
      repeat (400) offer_item(next_item(int'(threshold_cfg)));

      // Zero threshold: flat or falling samples must not launch. Then one
      // full-scale sample launches, with the supply at full scale so that a
      // battery check on the launch sample would show.
      drain_reports();
      write_csr(CSR_LAUNCH_THRESHOLD, '0);
      write_csr(CSR_SUPPLY_ALARM_LEVEL, CSR_DATA_W'(1));
      repeat (60) offer_item(next_item(0));
      item.func = FUNC_SAMPLE;
      item.altitude = '1;
      item.supply_level = '1;
      item.log_index = INDEX_W'($urandom);
      offer_item(item);

      // In flight: the log fills up and then stops; the alarm level at zero
      // must not latch low battery any more.
      drain_reports();
      write_csr(CSR_SUPPLY_ALARM_LEVEL, '0);
      write_csr(CSR_LAUNCH_THRESHOLD, CSR_DATA_W'($urandom));
      repeat (500) offer_item(next_item(65535));

      // A new fill value after launch must not touch the log.
      drain_reports();
      write_csr(CSR_FILL_VALUE, CSR_DATA_W'($urandom));
      write_csr(CSR_SUPPLY_ALARM_LEVEL, CSR_DATA_W'(1023));
      repeat (500) offer_item(next_item(65535));

      drain_reports();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ldfl_pkg.sv
design/ldfl_log_ram.sv
design/launch_detect_flight_logger.sv
design/ldfl_checker.sv
tb/sv/tb_top.sv
